@@ sv/nih_pkg.sv @@
`timescale 1ns / 1ps
package nih_pkg;

   localparam int HashW = 32;

   localparam logic [HashW-1:0] HASH_SEED = 32'd5381;

   localparam logic [1:0] OP_FIND        = 2'd0;
   localparam logic [1:0] OP_ADD         = 2'd1;
   localparam logic [1:0] OP_FIND_OR_ADD = 2'd2;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_ADDED     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_NON_ASCII = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;
   localparam logic [2:0] ST_EXHAUSTED = 3'd6;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_CASE    = 8'h20;
   localparam logic [7:0] CHAR_ASCII   = 8'h7F;

   typedef logic [2:0] status_type;

   // case-insensitive djb2-xor step
   function automatic logic [HashW-1:0] fold_byte(input logic [HashW-1:0] h,
                                                  input logic [7:0] c);
      logic [7:0] lc;
      lc = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         lc = c + CHAR_CASE;
      end
      return ((h << 5) + h) ^ {24'd0, lc};
   endfunction

endpackage

@@ sv/name_intern_hash_table.sv @@
`timescale 1ns / 1ps
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_opcode, req_char_code, req_char_valid, req_last
// rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_arena_index, rsp_byte_offset,
//         |           | rsp_name_hash
// Character transactions are accepted in the gather state. A transaction with
// last set then walks the bucket and entry memories: the head read, one step per
// chain entry walked, a decision, and one more step for a found place or a tail
// link update; the quotient estimate and remainder steps come first when
// BUCKET_COUNT is not a power of two. A non-ASCII or too-long name skips the table.
// After reset a clearing pass writes every bucket head, with req_stall high. A
// result waits in the output register while the next name is gathered; the table
// operation waits until that register is free.
module name_intern_hash_table
   import nih_pkg::*;
#(
   parameter int BUCKET_COUNT     = 1024,
   parameter int ARENA_BYTES      = 65536,
   parameter int ARENA_LIMIT      = 16,
   parameter int ENTRY_META_BYTES = 16,
   parameter int NAME_LIMIT       = 256,
   parameter int ENTRY_CAPACITY   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic        req_char_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_arena_index,
   output logic [15:0] rsp_byte_offset,
   output logic [31:0] rsp_name_hash
);

   localparam int BW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam bit BPOW = ((1 << $clog2(BUCKET_COUNT)) == BUCKET_COUNT);
   localparam int EW   = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
   localparam int UCW  = $clog2(ENTRY_CAPACITY + 1);
   localparam int AW   = (ARENA_LIMIT > 1) ? $clog2(ARENA_LIMIT) : 1;
   localparam int AUW  = $clog2(ARENA_LIMIT + 1);
   localparam int FW   = $clog2(ARENA_BYTES);
   localparam int CW   = $clog2(NAME_LIMIT + 1);
   localparam int SUMW = ((FW > 13) ? FW : 13) + 1;
   localparam int AXW  = (AW > 4) ? AW : 4;
   localparam int OXW  = (FW > 16) ? FW : 16;

   // floor(2^32 / BUCKET_COUNT); quotient estimate is low by at most one
   localparam logic [63:0]      RECIP64 = 64'h1_0000_0000 / 64'(BUCKET_COUNT);
   localparam logic [HashW-1:0] RECIP   = RECIP64[HashW-1:0];

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_ACC   = 4'd1;
   localparam logic [3:0] S_MOD   = 4'd2;
   localparam logic [3:0] S_HEAD  = 4'd3;
   localparam logic [3:0] S_HEADW = 4'd4;
   localparam logic [3:0] S_WALK  = 4'd5;
   localparam logic [3:0] S_DEC   = 4'd6;
   localparam logic [3:0] S_LINK  = 4'd7;
   localparam logic [3:0] S_PLACE = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;
   localparam logic [3:0] S_REM   = 4'd10;

   typedef struct packed {
      logic          full;
      logic [EW-1:0] idx;
   } ptr_type;

   typedef struct packed {
      logic [AW-1:0] arena;
      logic [FW-1:0] offset;
   } place_type;

   // memories
   ptr_type          head_mem  [BUCKET_COUNT];
   logic [HashW-1:0] hash_mem  [ENTRY_CAPACITY];
   ptr_type          link_mem  [ENTRY_CAPACITY];
   place_type        place_mem [ENTRY_CAPACITY];

   ptr_type          head_q;
   logic [HashW-1:0] hash_q;
   ptr_type          link_q;
   place_type        place_q;

   // control and datapath registers
   logic [3:0]       st_ff, st_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic [HashW-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             nasc_ff, nasc_in;
   logic [HashW-1:0] h_ff, h_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [1:0]       op_ff, op_in;
   logic [BW-1:0]    b_ff, b_in;
   logic [HashW-1:0] quo_ff, quo_in;
   logic [EW-1:0]    cur_ff, cur_in;
   logic [EW-1:0]    tail_ff, tail_in;
   logic [EW-1:0]    found_ff, found_in;
   logic             hit_ff, hit_in;
   logic             htail_ff, htail_in;
   logic [UCW-1:0]   used_ff, used_in;
   logic [AUW-1:0]   arenas_ff, arenas_in;
   logic [FW-1:0]    fill_ff, fill_in;
   status_type       res_st_ff, res_st_in;
   logic [AW-1:0]    res_ar_ff, res_ar_in;
   logic [FW-1:0]    res_off_ff, res_off_in;
   logic             ov_ff, ov_in;
   status_type       o_st_ff, o_st_in;
   logic [AW-1:0]    o_ar_ff, o_ar_in;
   logic [FW-1:0]    o_off_ff, o_off_in;
   logic [HashW-1:0] o_h_ff, o_h_in;

   // memory ports
   logic             head_we;
   logic [BW-1:0]    head_wa;
   ptr_type          head_wd;
   logic             ent_we;
   logic             link_we;
   logic [EW-1:0]    link_wa;
   ptr_type          link_wd;
   logic [EW-1:0]    ent_ra;
   logic [EW-1:0]    new_e;
   place_type        new_place;

   logic             take;
   logic [HashW-1:0] fold_h;
   logic [63:0]      prod_w;
   logic [HashW-1:0] rem_w;
   logic [SUMW-1:0]  size_w;
   logic [SUMW-1:0]  fill_sum;
   logic [AXW-1:0]   ar_x;
   logic [OXW-1:0]   off_x;

   assign req_stall = (st_ff != S_ACC);
   assign take      = req_valid && !req_stall;
   assign fold_h    = fold_byte(acc_ff, req_char_code);
   assign prod_w    = {32'd0, h_ff} * {32'd0, RECIP};
   assign rem_w     = h_ff - HashW'(quo_ff * HashW'(BUCKET_COUNT));
   assign size_w    = SUMW'(ENTRY_META_BYTES) + SUMW'(len_ff) + SUMW'(1);
   assign fill_sum  = SUMW'(fill_ff) + size_w;
   assign new_e     = used_ff[EW-1:0];
   assign ent_ra    = (st_ff == S_HEADW) ? head_q.idx : link_q.idx;

   always_ff @(posedge clock) begin
      head_q  <= head_mem[b_ff];
      hash_q  <= hash_mem[ent_ra];
      link_q  <= link_mem[ent_ra];
      place_q <= place_mem[found_ff];
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (ent_we) begin
         hash_mem[new_e]  <= h_ff;
         place_mem[new_e] <= new_place;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
   end

   always_comb begin
      st_in      = st_ff;
      clr_in     = clr_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      nasc_in    = nasc_ff;
      h_in       = h_ff;
      len_in     = len_ff;
      op_in      = op_ff;
      b_in       = b_ff;
      quo_in     = quo_ff;
      cur_in     = cur_ff;
      tail_in    = tail_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      htail_in   = htail_ff;
      used_in    = used_ff;
      arenas_in  = arenas_ff;
      fill_in    = fill_ff;
      res_st_in  = res_st_ff;
      res_ar_in  = res_ar_ff;
      res_off_in = res_off_ff;
      ov_in      = ov_ff;
      o_st_in    = o_st_ff;
      o_ar_in    = o_ar_ff;
      o_off_in   = o_off_ff;
      o_h_in     = o_h_ff;
      head_we    = 1'b0;
      head_wa    = b_ff;
      head_wd    = '{full: 1'b1, idx: new_e};
      ent_we     = 1'b0;
      link_we    = 1'b0;
      link_wa    = new_e;
      link_wd    = '{full: 1'b0, idx: '0};
      new_place  = '{arena: AW'(arenas_ff - AUW'(1)), offset: fill_ff};

      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      unique case (st_ff)
         S_CLR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = '0;
            clr_in  = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKET_COUNT - 1)) begin
               st_in = S_ACC;
            end
         end
         S_ACC: begin
            if (take) begin
               if (req_char_valid) begin
                  acc_in = fold_h;
                  if (req_char_code > CHAR_ASCII) begin
                     nasc_in = 1'b1;
                  end
                  if (cnt_ff < CW'(NAME_LIMIT)) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
               if (req_last) begin
                  h_in      = acc_in;
                  len_in    = cnt_in;
                  op_in     = req_opcode;
                  hit_in    = 1'b0;
                  htail_in  = 1'b0;
                  res_ar_in = '0;
                  res_off_in = '0;
                  b_in      = '0;
                  priority if (nasc_in) begin
                     res_st_in = ST_NON_ASCII;
                     st_in     = S_RESP;
                  end else if (cnt_in >= CW'(NAME_LIMIT)) begin
                     res_st_in = ST_TOO_LONG;
                     st_in     = S_RESP;
                  end else if (BPOW) begin
                     b_in  = BW'(acc_in & HashW'(BUCKET_COUNT - 1));
                     st_in = S_HEAD;
                  end else begin
                     st_in = S_MOD;
                  end
                  acc_in    = HASH_SEED;
                  cnt_in    = '0;
                  nasc_in   = 1'b0;
               end
            end
         end
         S_MOD: begin
            // quotient estimate from the reciprocal
            quo_in = prod_w[63:32];
            st_in  = S_REM;
         end
         S_REM: begin
            if (rem_w >= HashW'(BUCKET_COUNT)) begin
               b_in = BW'(rem_w - HashW'(BUCKET_COUNT));
            end else begin
               b_in = BW'(rem_w);
            end
            st_in = S_HEAD;
         end
         S_HEAD: begin
            st_in = S_HEADW;
         end
         S_HEADW: begin
            if (head_q.full) begin
               cur_in = head_q.idx;
               st_in  = S_WALK;
            end else begin
               st_in = S_DEC;
            end
         end
         S_WALK: begin
            tail_in  = cur_ff;
            htail_in = 1'b1;
            if (hash_q == h_ff) begin
               hit_in   = 1'b1;
               found_in = cur_ff;
               st_in    = S_DEC;
            end else if (!link_q.full) begin
               st_in = S_DEC;
            end else begin
               cur_in = link_q.idx;
            end
         end
         S_DEC: begin
            st_in = S_RESP;
            priority if (hit_ff && op_ff != OP_ADD) begin
               res_st_in = ST_FOUND;
               st_in     = S_PLACE;
            end else if (hit_ff) begin
               res_st_in = ST_DUPLICATE;
            end else if (op_ff != OP_ADD && op_ff != OP_FIND_OR_ADD) begin
               res_st_in = ST_NOT_FOUND;
            end else if (used_ff >= UCW'(ENTRY_CAPACITY) ||
                         size_w >= SUMW'(ARENA_BYTES)) begin
               res_st_in = ST_EXHAUSTED;
            end else if (fill_sum >= SUMW'(ARENA_BYTES) &&
                         arenas_ff >= AUW'(ARENA_LIMIT)) begin
               res_st_in = ST_EXHAUSTED;
            end else begin
               if (fill_sum >= SUMW'(ARENA_BYTES)) begin
                  // roll over to a fresh arena
                  new_place = '{arena: AW'(arenas_ff), offset: '0};
                  arenas_in = arenas_ff + AUW'(1);
                  fill_in   = FW'(size_w);
               end else begin
                  fill_in = FW'(fill_sum);
               end
               ent_we     = 1'b1;
               link_we    = 1'b1;
               used_in    = used_ff + UCW'(1);
               res_st_in  = ST_ADDED;
               res_ar_in  = new_place.arena;
               res_off_in = new_place.offset;
               if (htail_ff) begin
                  st_in = S_LINK;
               end else begin
                  head_we = 1'b1;
               end
            end
         end
         S_LINK: begin
            link_we = 1'b1;
            link_wa = tail_ff;
            link_wd = '{full: 1'b1, idx: EW'(used_ff - UCW'(1))};
            st_in   = S_RESP;
         end
         S_PLACE: begin
            res_ar_in  = place_q.arena;
            res_off_in = place_q.offset;
            st_in      = S_RESP;
         end
         S_RESP: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in    = 1'b1;
               o_st_in  = res_st_ff;
               o_ar_in  = res_ar_ff;
               o_off_in = res_off_ff;
               o_h_in   = h_ff;
               st_in    = S_ACC;
            end
         end
         default: begin
            st_in = S_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_CLR;
         clr_ff    <= '0;
         acc_ff    <= HASH_SEED;
         cnt_ff    <= '0;
         nasc_ff   <= 1'b0;
         used_ff   <= '0;
         arenas_ff <= AUW'(1);
         fill_ff   <= '0;
         ov_ff     <= 1'b0;
         hit_ff    <= 1'b0;
         htail_ff  <= 1'b0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         nasc_ff   <= nasc_in;
         used_ff   <= used_in;
         arenas_ff <= arenas_in;
         fill_ff   <= fill_in;
         ov_ff     <= ov_in;
         hit_ff    <= hit_in;
         htail_ff  <= htail_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff       <= h_in;
      len_ff     <= len_in;
      op_ff      <= op_in;
      b_ff       <= b_in;
      quo_ff     <= quo_in;
      cur_ff     <= cur_in;
      tail_ff    <= tail_in;
      found_ff   <= found_in;
      res_st_ff  <= res_st_in;
      res_ar_ff  <= res_ar_in;
      res_off_ff <= res_off_in;
      o_st_ff    <= o_st_in;
      o_ar_ff    <= o_ar_in;
      o_off_ff   <= o_off_in;
      o_h_ff     <= o_h_in;
   end

   assign ar_x            = AXW'(o_ar_ff);
   assign off_x           = OXW'(o_off_ff);
   assign rsp_valid       = ov_ff;
   assign rsp_status      = o_st_ff;
   assign rsp_arena_index = ar_x[3:0];
   assign rsp_byte_offset = off_x[15:0];
   assign rsp_name_hash   = o_h_ff;

   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UCW'(ENTRY_CAPACITY))
      else $error("entry count above capacity");

   a_arena_range: assert property (@(posedge clock) disable iff (reset)
      arenas_ff >= AUW'(1) && arenas_ff <= AUW'(ARENA_LIMIT))
      else $error("arena count out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      SUMW'(fill_ff) < SUMW'(ARENA_BYTES))
      else $error("arena fill past arena size");

   a_walk_written: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_WALK |-> UCW'(cur_ff) < used_ff)
      else $error("chain walk reached an unwritten entry");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DEC && res_st_in == ST_ADDED |=> used_ff == $past(used_ff) + UCW'(1))
      else $error("add did not allocate an entry");

endmodule

@@ test/name_intern_hash_table_test.sv @@
`timescale 1ns / 1ps
module name_intern_hash_table_test;
   import nih_pkg::*;

   localparam int BUCKETS     = 1024;
   localparam int ARENA_SIZE  = 65536;
   localparam int ARENA_MAX   = 16;
   localparam int META_BYTES  = 16;
   localparam int NAME_MAX    = 256;
   localparam int ENTRY_MAX   = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [1:0] OP_FIND_ALT = 2'd3;

   typedef struct {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic       char_valid;
      logic       last;
   } char_txn_t;

   typedef struct {
      status_type   status;
      logic [3:0]   arena_index;
      logic [15:0]  byte_offset;
      logic [31:0]  name_hash;
   } lookup_t;

   typedef logic [7:0] name_bytes_t[$];

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_opcode = 0;
   logic [7:0] req_char_code = 0;
   logic req_char_valid = 0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_arena_index;
   logic [15:0] rsp_byte_offset;
   logic [31:0] rsp_name_hash;

   name_intern_hash_table DUT (.*);

   char_txn_t pending_chars[$];
   lookup_t   expected_lookups[$];
   logic      req_fire = 0;
   int        total_chars, accepted_chars, lookups_seen, errors, cycles;
   int        send_pct, recv_pct, hold_left;
   bit        hold_done;
   int        status_seen[7];

   // predictor state
   logic [31:0] acc_hash;
   int          acc_len;
   bit          acc_wide;
   bit          head_ok[BUCKETS];
   int          head_slot[BUCKETS];
   logic [31:0] slot_hash[ENTRY_MAX];
   bit          link_ok[ENTRY_MAX];
   int          link_slot[ENTRY_MAX];
   int          slot_arena[ENTRY_MAX];
   int          slot_offset[ENTRY_MAX];
   int          arenas_open, fill_bytes, slots_used;

   name_bytes_t name_pool[48];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void predict_intern(input char_txn_t t);
      logic [7:0] c;
      lookup_t    r;
      int b, cur, tail, found, slot, size;
      bit hit, have_tail;
      c = t.char_code;
      hit = 0;
      have_tail = 0;
      slot = 0;
      tail = 0;
      found = 0;
      if (t.char_valid) begin
         if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
         acc_hash = (acc_hash * 33) ^ {24'd0, c};
         if (t.char_code > 8'h7F) acc_wide = 1;
         if (acc_len < NAME_MAX) acc_len++;
      end
      if (!t.last) return;
      r.name_hash = acc_hash;
      r.arena_index = '0;
      r.byte_offset = '0;
      b = acc_hash % BUCKETS;
      if (acc_wide) r.status = ST_NON_ASCII;
      else if (acc_len >= NAME_MAX) r.status = ST_TOO_LONG;
      else begin
         if (head_ok[b]) begin
            cur = head_slot[b];
            forever begin
               if (slot_hash[cur] == acc_hash && !hit) begin
                  hit = 1;
                  found = cur;
               end
               tail = cur;
               have_tail = 1;
               if (!link_ok[cur]) break;
               cur = link_slot[cur];
            end
         end
         if (hit && t.opcode != OP_ADD) begin
            r.status = ST_FOUND;
            slot = found;
         end else if (hit) r.status = ST_DUPLICATE;
         else if (t.opcode == OP_FIND || t.opcode == OP_FIND_ALT) r.status = ST_NOT_FOUND;
         else begin
            size = META_BYTES + acc_len + 1;
            r.status = ST_ADDED;
            if (slots_used >= ENTRY_MAX || size >= ARENA_SIZE) r.status = ST_EXHAUSTED;
            else if (fill_bytes + size >= ARENA_SIZE) begin
               if (arenas_open + 1 > ARENA_MAX) r.status = ST_EXHAUSTED;
               else begin
                  arenas_open++;
                  fill_bytes = 0;
               end
            end
            if (r.status == ST_ADDED) begin
               slot = slots_used++;
               slot_hash[slot] = acc_hash;
               link_ok[slot] = 0;
               slot_arena[slot] = arenas_open - 1;
               slot_offset[slot] = fill_bytes;
               fill_bytes += size;
               if (have_tail) begin
                  link_slot[tail] = slot;
                  link_ok[tail] = 1;
               end else begin
                  head_slot[b] = slot;
                  head_ok[b] = 1;
               end
            end
         end
         if (r.status == ST_FOUND || r.status == ST_ADDED) begin
            r.arena_index = 4'(slot_arena[slot]);
            r.byte_offset = 16'(slot_offset[slot]);
         end
      end
      expected_lookups.push_back(r);
      acc_hash = HASH_SEED;
      acc_len = 0;
      acc_wide = 0;
   endfunction

   // queue one name; noisy inserts empty transactions in between
   task automatic queue_name(input name_bytes_t s, input logic [1:0] op, input bit noisy);
      char_txn_t t;
      bit trail;
      trail = (s.size() == 0) || ($urandom_range(0, 5) == 0);
      foreach (s[i]) begin
         if (noisy && $urandom_range(0, 7) == 0) begin
            t.opcode = 2'($urandom);
            t.char_code = 8'($urandom);
            t.char_valid = 0;
            t.last = 0;
            pending_chars.push_back(t);
         end
         t.char_code = s[i];
         t.char_valid = 1;
         t.last = (i == s.size() - 1) && !trail;
         t.opcode = t.last ? op : 2'($urandom);
         pending_chars.push_back(t);
      end
      if (trail) begin
         t.opcode = op;
         t.char_code = 8'($urandom);
         t.char_valid = 0;
         t.last = 1;
         pending_chars.push_back(t);
      end
   endtask

   function automatic name_bytes_t word(input int n, input logic [7:0] lo, input logic [7:0] hi);
      name_bytes_t s;
      repeat (n) s.push_back(8'($urandom_range(lo, hi)));
      return s;
   endfunction

   function automatic name_bytes_t shuffle_case(input name_bytes_t s);
      foreach (s[i])
         if (s[i] >= 8'h61 && s[i] <= 8'h7A && $urandom_range(0, 1)) s[i] = s[i] - 8'h20;
      return s;
   endfunction

   initial begin
      name_bytes_t s;
      int pick;
      acc_hash = HASH_SEED;
      acc_len = 0;
      acc_wide = 0;
      arenas_open = 1;
      fill_bytes = 0;
      slots_used = 0;
      foreach (name_pool[i]) name_pool[i] = word($urandom_range(1, 6), 8'h61, 8'h7A);

      // directed: empty name, case folding, all opcodes, byte extremes, lengths
      s = {};
      queue_name(s, OP_FIND, 0);
      queue_name(s, OP_ADD, 0);
      queue_name(s, OP_ADD, 0);
      queue_name(s, OP_FIND_ALT, 0);
      s = {8'h41, 8'h62, 8'h5A};
      queue_name(s, OP_ADD, 0);
      s = {8'h61, 8'h42, 8'h7A};
      queue_name(s, OP_FIND, 0);
      queue_name(s, OP_FIND_OR_ADD, 0);
      s = {8'h00, 8'h7F, 8'h40, 8'h5B, 8'h60, 8'h7B};
      queue_name(s, OP_FIND_ALT, 0);
      queue_name(s, OP_FIND_OR_ADD, 0);
      queue_name(s, OP_FIND_OR_ADD, 0);
      s = {8'h61, 8'hFF};
      queue_name(s, OP_ADD, 0);
      s = {8'h80};
      queue_name(s, OP_FIND, 0);
      s = {8'hAA, 8'h55};
      queue_name(s, OP_ADD, 0);
      queue_name(word(NAME_MAX - 1, 8'h20, 8'h7E), OP_ADD, 0);
      queue_name(word(NAME_MAX, 8'h20, 8'h7E), OP_ADD, 0);

      // random: mostly pool names with case noise, some fresh and broken ones
      repeat (60) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) s = shuffle_case(name_pool[$urandom_range(0, 47)]);
         else if (pick < 90) s = word($urandom_range(0, 5), 8'h00, 8'h7F);
         else s = word($urandom_range(1, 5), 8'h00, 8'hFF);
         queue_name(s, 2'($urandom), pick >= 80);
      end
      repeat (20) queue_name(shuffle_case(name_pool[$urandom_range(0, 47)]), 2'($urandom), 0);

      total_chars = pending_chars.size();
      repeat (3) @(posedge clock);
      reset <= 0;
      wait (pending_chars.size() == 0 && !req_valid);
      wait (expected_lookups.size() == 0);
      repeat (60) @(posedge clock);
      $display("Covered %0d character transactions, %0d lookups; status counts:",
               accepted_chars, lookups_seen);
      $display("  found %0d added %0d missing %0d dup %0d non-ascii %0d long %0d full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (errors == 0) $display("name_intern_hash_table_test: PASS");
      else $display("name_intern_hash_table_test: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("name_intern_hash_table_test: FAIL");
         $finish;
      end
   end

   // track accepted characters and predict
   always @(posedge clock) begin
      char_txn_t t;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         t.opcode = req_opcode;
         t.char_code = req_char_code;
         t.char_valid = req_char_valid;
         t.last = req_last;
         predict_intern(t);
         accepted_chars++;
      end
   end

   // check results
   always @(posedge clock) begin
      lookup_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         lookups_seen++;
         if (rsp_status < 7) status_seen[rsp_status]++;
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result status %0d hash %h", $time, rsp_status,
                     rsp_name_hash);
            errors++;
         end else begin
            e = expected_lookups.pop_front();
            if (rsp_status !== e.status || rsp_arena_index !== e.arena_index ||
                rsp_byte_offset !== e.byte_offset || rsp_name_hash !== e.name_hash) begin
               $display("%0t: expected st %0d ar %0d off %0d hash %h, got st %0d ar %0d off %0d hash %h",
                        $time, e.status, e.arena_index, e.byte_offset, e.name_hash,
                        rsp_status, rsp_arena_index, rsp_byte_offset, rsp_name_hash);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (accepted_chars * 3 < total_chars) begin
         send_pct = 32;
         recv_pct = 52;
      end else if (accepted_chars * 3 < total_chars * 2) begin
         send_pct = 52;
         recv_pct = 32;
      end else begin
         send_pct = 0;
         recv_pct = 0;
      end
   end

   // driver: advance after each accepted transaction
   always @(negedge clock) begin
      char_txn_t t;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_chars.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
            t = pending_chars.pop_front();
            req_valid <= 1;
            req_opcode <= t.opcode;
            req_char_code <= t.char_code;
            req_char_valid <= t.char_valid;
            req_last <= t.last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver: random stalls plus one long hold to back up the block
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_chars >= 150) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_pct);
         end
      end
   end

endmodule
